FILE: sv/rgbe_rle_pkg.sv
// Shared types and constants for the RGBE scanline run-length decoder.
package rgbe_rle_pkg;

  localparam int unsigned WidthW = 16;
  localparam int unsigned ByteW  = 8;

  localparam logic [WidthW-1:0] LineWidthRst = 16'd256;
  localparam logic [ByteW-1:0]  RunBase      = 8'd128;
  localparam logic [ByteW-1:0]  HdrTag       = 8'd2;
  localparam logic [1:0]        PlaneLast    = 2'd3;
  localparam logic [1:0]        HdrLastIdx   = 2'd3;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    ST_HEADER   = 7'b0000001,
    ST_HDR_EMIT = 7'b0000010,
    ST_FLAT     = 7'b0000100,
    ST_COUNT    = 7'b0001000,
    ST_RUNVAL   = 7'b0010000,
    ST_RUN_EMIT = 7'b0100000,
    ST_LITERAL  = 7'b1000000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic hdr_store;   // keep one header byte
    logic hdr_check;   // fourth header byte: reset line position
    logic hdr_emit;    // emit one header byte as a flat pixel channel
    logic flat_step;   // emit one flat byte
    logic count_load;  // load run or literal count
    logic run_load;    // latch run byte and clip run to the line
    logic run_emit;    // emit one or two run bytes
    logic lit_step;    // consume one literal byte
    logic plane_next;  // close the current plane
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic hdr_full;
    logic hdr_match;
    logic hdr_end;
    logic plane_last;
    logic flat_end;
    logic cnt_run;
    logic run_zero;
    logic run_done_now;
    logic run_done;
    logic rem_last;
    logic lit_last;
    logic lit_end_plane;
  } sts_t;

endpackage

FILE: sv/rgbe_scanline_rle_decoder.sv
// Top level of the RGBE scanline run-length decoder.
//
//   port group  direction  handshake         payload
//   in_         input      in_valid/ready    in_byte
//   out_        output     out_valid/ready   channel, position, byte_a/b, byte_count, flags
//   cfg_        input      cfg_we            cfg_data (line width)
//
// One input word a cycle, while the output register has room, for header, count,
// literal and flat bytes; each word that yields a result moves through the single output register.
// A run value word is latched, then its n clipped bytes drain two to an output word;
// a flat-line header emits its four header bytes as its first pixel, one per channel.
// Synchronous active-low reset sets the width to 256 and waits for a header.
// A stalled output holds the result and blocks input until it is taken.
module rgbe_scanline_rle_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rgbe_rle_pkg::WidthW-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgbe_rle_pkg::ByteW-1:0]    in_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_channel,
  output logic [rgbe_rle_pkg::WidthW-1:0]   out_position,
  output logic [rgbe_rle_pkg::ByteW-1:0]    out_byte_a,
  output logic [rgbe_rle_pkg::ByteW-1:0]    out_byte_b,
  output logic [1:0]                        out_byte_count,
  output logic                              out_flat_line,
  output logic                              out_overrun,
  output logic                              out_line_end
);
  import rgbe_rle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rgbe_rle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgbe_rle_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_byte        (in_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_position   (out_position),
    .out_byte_a     (out_byte_a),
    .out_byte_b     (out_byte_b),
    .out_byte_count (out_byte_count),
    .out_flat_line  (out_flat_line),
    .out_overrun    (out_overrun),
    .out_line_end   (out_line_end)
  );

endmodule

FILE: sv/rgbe_rle_ctrl.sv
// Controller state machine for the RGBE scanline decoder.
module rgbe_rle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rgbe_rle_pkg::sts_t   sts,
  output rgbe_rle_pkg::cmd_t   cmd
);
  import rgbe_rle_pkg::*;

  state_t state_r, state_nxt;
  logic   takes_input;
  logic   acc;

  // Accept a word only in input states and with room in the output register
  always_comb begin
    case (state_r)
      ST_HEADER, ST_FLAT, ST_COUNT, ST_RUNVAL, ST_LITERAL: takes_input = 1'b1;
      default:                                             takes_input = 1'b0;
    endcase
  end

  assign in_ready = takes_input && sts.out_free;
  assign acc      = in_valid && in_ready;

  // Issue commands and pick the next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_HEADER: begin
        if (acc) begin
          if (!sts.hdr_full) begin
            cmd.hdr_store = 1'b1;
          end else begin
            cmd.hdr_check = 1'b1;
            state_nxt     = sts.hdr_match ? ST_COUNT : ST_HDR_EMIT;
          end
        end
      end
      ST_HDR_EMIT: begin
        if (sts.out_free) begin
          cmd.hdr_emit = 1'b1;
          if (sts.plane_last) begin
            state_nxt = sts.hdr_end ? ST_HEADER : ST_FLAT;
          end
        end
      end
      ST_FLAT: begin
        if (acc) begin
          cmd.flat_step = 1'b1;
          if (sts.flat_end) begin
            state_nxt = ST_HEADER;
          end
        end
      end
      ST_COUNT: begin
        if (acc) begin
          cmd.count_load = 1'b1;
          state_nxt      = sts.cnt_run ? ST_RUNVAL : ST_LITERAL;
        end
      end
      ST_RUNVAL: begin
        if (acc) begin
          cmd.run_load = 1'b1;
          if (!sts.run_zero) begin
            state_nxt = ST_RUN_EMIT;
          end else if (sts.run_done_now) begin
            cmd.plane_next = 1'b1;
            state_nxt      = sts.plane_last ? ST_HEADER : ST_COUNT;
          end else begin
            state_nxt = ST_COUNT;
          end
        end
      end
      ST_RUN_EMIT: begin
        if (sts.out_free) begin
          cmd.run_emit = 1'b1;
          if (sts.rem_last) begin
            if (sts.run_done) begin
              cmd.plane_next = 1'b1;
              state_nxt      = sts.plane_last ? ST_HEADER : ST_COUNT;
            end else begin
              state_nxt = ST_COUNT;
            end
          end
        end
      end
      ST_LITERAL: begin
        if (acc) begin
          cmd.lit_step = 1'b1;
          if (sts.lit_last) begin
            if (sts.lit_end_plane) begin
              cmd.plane_next = 1'b1;
              state_nxt      = sts.plane_last ? ST_HEADER : ST_COUNT;
            end else begin
              state_nxt = ST_COUNT;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_HEADER;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/rgbe_rle_dp.sv
// Datapath: line width register, header store, counters and output register.
module rgbe_rle_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rgbe_rle_pkg::WidthW-1:0]   cfg_data,
  input  logic [rgbe_rle_pkg::ByteW-1:0]    in_byte,
  input  rgbe_rle_pkg::cmd_t                cmd,
  output rgbe_rle_pkg::sts_t                sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_channel,
  output logic [rgbe_rle_pkg::WidthW-1:0]   out_position,
  output logic [rgbe_rle_pkg::ByteW-1:0]    out_byte_a,
  output logic [rgbe_rle_pkg::ByteW-1:0]    out_byte_b,
  output logic [1:0]                        out_byte_count,
  output logic                              out_flat_line,
  output logic                              out_overrun,
  output logic                              out_line_end
);
  import rgbe_rle_pkg::*;

  // Configuration and line state
  logic [WidthW-1:0] width_r;
  logic [ByteW-1:0]  hdr_r [4];
  logic [1:0]        hdr_idx_r, hdr_idx_nxt;
  logic [1:0]        plane_r, plane_nxt;
  logic [WidthW-1:0] pos_r, pos_nxt;
  logic [ByteW-1:0]  lit_left_r, lit_left_nxt;
  logic [ByteW-1:0]  run_cnt_r, run_cnt_nxt;
  logic [ByteW-1:0]  run_byte_r;
  logic [ByteW-1:0]  rem_r, rem_nxt;
  logic              dropped_r, done_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [WidthW-1:0] opos_r, opos_nxt;
  logic [ByteW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              flat_r, flat_nxt, ovr_r, ovr_nxt, end_r, end_nxt;
  logic              emit;

  // Derived values
  logic [WidthW:0]   pos_inc;
  logic              pos_lt_w;
  logic [WidthW-1:0] avail;
  logic [ByteW-1:0]  run_valid;
  logic [WidthW:0]   run_end;
  logic              two;
  logic [WidthW:0]   lit_pos;

  assign sts.out_free = !out_valid_r || out_ready;

  // Compare line position against the width
  always_comb begin
    pos_inc   = {1'b0, pos_r} + {{WidthW{1'b0}}, 1'b1};
    pos_lt_w  = pos_r < width_r;
    avail     = pos_lt_w ? (width_r - pos_r) : '0;
    run_valid = ({{(WidthW-ByteW){1'b0}}, run_cnt_r} < avail) ? run_cnt_r : avail[ByteW-1:0];
    run_end   = {1'b0, pos_r} + {{(WidthW-ByteW+1){1'b0}}, run_valid};
    two       = rem_r >= 8'd2;
    lit_pos   = pos_lt_w ? pos_inc : {1'b0, pos_r};
  end

  // Report status
  assign sts.hdr_full      = hdr_idx_r == HdrLastIdx;
  assign sts.hdr_match     = (hdr_r[0] == HdrTag) && (hdr_r[1] == HdrTag) &&
                             ({hdr_r[2], in_byte} == width_r);
  assign sts.hdr_end       = width_r <= 16'd1;
  assign sts.plane_last    = plane_r == PlaneLast;
  assign sts.flat_end      = (plane_r == PlaneLast) && (pos_inc >= {1'b0, width_r});
  assign sts.cnt_run       = in_byte > RunBase;
  assign sts.run_zero      = run_valid == '0;
  assign sts.run_done_now  = run_end >= {1'b0, width_r};
  assign sts.run_done      = done_r;
  assign sts.rem_last      = rem_r <= 8'd2;
  assign sts.lit_last      = lit_left_r <= 8'd1;
  assign sts.lit_end_plane = lit_pos >= {1'b0, width_r};

  // Update counters and build the next result word
  always_comb begin
    hdr_idx_nxt  = hdr_idx_r;
    plane_nxt    = plane_r;
    pos_nxt      = pos_r;
    lit_left_nxt = lit_left_r;
    run_cnt_nxt  = run_cnt_r;
    rem_nxt      = rem_r;
    emit         = 1'b0;
    ch_nxt       = plane_r;
    opos_nxt     = pos_r;
    a_nxt        = in_byte;
    b_nxt        = '0;
    cnt_nxt      = 2'd1;
    flat_nxt     = 1'b0;
    ovr_nxt      = 1'b0;
    end_nxt      = 1'b0;

    if (cmd.hdr_store) begin
      hdr_idx_nxt = hdr_idx_r + 2'd1;
    end
    if (cmd.hdr_check) begin
      hdr_idx_nxt = '0;
      plane_nxt   = '0;
      pos_nxt     = '0;
    end
    if (cmd.hdr_emit) begin
      emit     = 1'b1;
      opos_nxt = '0;
      a_nxt    = hdr_r[plane_r];
      flat_nxt = 1'b1;
      end_nxt  = sts.plane_last && sts.hdr_end;
      if (sts.plane_last) begin
        plane_nxt = '0;
        pos_nxt   = sts.hdr_end ? '0 : 16'd1;
      end else begin
        plane_nxt = plane_r + 2'd1;
      end
    end
    if (cmd.flat_step) begin
      emit     = 1'b1;
      flat_nxt = 1'b1;
      end_nxt  = sts.flat_end;
      if (sts.flat_end) begin
        plane_nxt = '0;
        pos_nxt   = '0;
      end else if (sts.plane_last) begin
        plane_nxt = '0;
        pos_nxt   = pos_inc[WidthW-1:0];
      end else begin
        plane_nxt = plane_r + 2'd1;
      end
    end
    if (cmd.count_load) begin
      lit_left_nxt = (in_byte == '0) ? 8'd1 : in_byte;
      run_cnt_nxt  = in_byte - RunBase;
    end
    if (cmd.run_load) begin
      rem_nxt     = run_valid;
      run_cnt_nxt = '0;
    end
    if (cmd.run_emit) begin
      emit    = 1'b1;
      a_nxt   = run_byte_r;
      b_nxt   = two ? run_byte_r : '0;
      cnt_nxt = two ? 2'd2 : 2'd1;
      ovr_nxt = sts.rem_last && dropped_r;
      end_nxt = sts.rem_last && done_r && sts.plane_last;
      rem_nxt = rem_r - {6'd0, cnt_nxt};
      pos_nxt = pos_r + {14'd0, cnt_nxt};
    end
    if (cmd.lit_step) begin
      if (pos_lt_w) begin
        emit    = 1'b1;
        ovr_nxt = (pos_inc >= {1'b0, width_r}) && (lit_left_r > 8'd1);
        end_nxt = (pos_inc >= {1'b0, width_r}) && sts.plane_last;
        pos_nxt = pos_inc[WidthW-1:0];
      end
      if (lit_left_r != '0) begin
        lit_left_nxt = lit_left_r - 8'd1;
      end
    end
    // Close the plane: restart position, advance or wrap the plane
    if (cmd.plane_next) begin
      pos_nxt   = '0;
      plane_nxt = sts.plane_last ? '0 : (plane_r + 2'd1);
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= LineWidthRst;
      hdr_idx_r   <= '0;
      plane_r     <= '0;
      pos_r       <= '0;
      lit_left_r  <= '0;
      run_cnt_r   <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_data;
      end
      hdr_idx_r   <= hdr_idx_nxt;
      plane_r     <= plane_nxt;
      pos_r       <= pos_nxt;
      lit_left_r  <= lit_left_nxt;
      run_cnt_r   <= run_cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: header bytes, run latch, result word
  always_ff @(posedge clk) begin
    if (cmd.hdr_store) begin
      hdr_r[hdr_idx_r] <= in_byte;
    end
    if (cmd.hdr_check) begin
      hdr_r[HdrLastIdx] <= in_byte;
    end
    if (cmd.run_load) begin
      run_byte_r <= in_byte;
      dropped_r  <= run_cnt_r > run_valid;
      done_r     <= sts.run_done_now;
    end
    if (emit) begin
      ch_r   <= ch_nxt;
      opos_r <= opos_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      cnt_r  <= cnt_nxt;
      flat_r <= flat_nxt;
      ovr_r  <= ovr_nxt;
      end_r  <= end_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = ch_r;
  assign out_position   = opos_r;
  assign out_byte_a     = a_r;
  assign out_byte_b     = b_r;
  assign out_byte_count = cnt_r;
  assign out_flat_line  = flat_r;
  assign out_overrun    = ovr_r;
  assign out_line_end   = end_r;

endmodule
